// ===== hw/rtl/adrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADRC package
// Shared types and constants for the ADRC observer/controller datapath.
// ----------------------------------------------------------------------------
package adrc_pkg;

  // Width of one multiplier digit and of the full multiplier operand
  localparam int unsigned DIGIT_W = 16;
  localparam int unsigned OPB_W   = 48;

  // Configuration register index
  typedef enum logic [2:0] {
    REG_TARGET,
    REG_BANDWIDTH,
    REG_PLANT_GAIN,
    REG_PLANT_GAIN_INV,
    REG_PROP_GAIN,
    REG_RATE_GAIN,
    REG_DEADBAND,
    REG_UNUSED
  } reg_index_e;

  // Right shift applied to a product before saturation
  typedef enum logic [1:0] {
    SH_0,
    SH_8,
    SH_16,
    SH_24
  } shift_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic       start;
    logic       a_signed;
    logic [1:0] digits;
    shift_e     shift;
  } mul_cmd_t;

endpackage

// ===== hw/rtl/adrc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADRC shared multiplier
// Digit-serial sign-magnitude multiplier, one 16-bit digit of b per cycle,
// most significant digit first; result shifted right and saturated.
// ----------------------------------------------------------------------------
module adrc_mul
  import adrc_pkg::*;
#(
  parameter int unsigned STATE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mul_cmd_t               cmd_i,
  input  logic [STATE_WIDTH-1:0] a_i,
  input  logic [OPB_W-1:0]       b_i,
  output logic                   done_o,
  output logic [OPB_W-1:0]       raw_o,
  output logic [STATE_WIDTH-1:0] res_o
);

  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned PW = STATE_WIDTH + OPB_W;
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW-1:0]         mag_q;
  logic                  neg_q;
  logic [OPB_W-1:0]      b_q;
  shift_e                sh_q;
  logic [1:0]            cnt_q;
  logic                  done_q;
  logic [PW-1:0]         prod_q;
  logic                  a_neg;
  logic [SW-1:0]         a_mag;
  logic [SW+DIGIT_W-1:0] pp;
  logic [PW-1:0]         mag_sh;
  logic                  over;

  assign a_neg = cmd_i.a_signed & a_i[SW-1];
  assign a_mag = a_neg ? ('0 - a_i) : a_i;
  assign pp    = mag_q * b_q[OPB_W-1 -: DIGIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 2'd1) && !cmd_i.start;
      if (cmd_i.start) begin
        cnt_q <= cmd_i.digits;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mag_q  <= a_mag;
      neg_q  <= a_neg;
      sh_q   <= cmd_i.shift;
      prod_q <= '0;
      unique case (cmd_i.digits)
        2'd1:    b_q <= b_i << (2 * DIGIT_W);
        2'd2:    b_q <= b_i << DIGIT_W;
        default: b_q <= b_i;
      endcase
    end else if (cnt_q != '0) begin
      prod_q <= (prod_q << DIGIT_W) + PW'(pp);
      b_q    <= b_q << DIGIT_W;
    end
  end

  always_comb begin
    unique case (sh_q)
      SH_0:    mag_sh = prod_q;
      SH_8:    mag_sh = prod_q >> 8;
      SH_16:   mag_sh = prod_q >> 16;
      default: mag_sh = prod_q >> 24;
    endcase
    over = |mag_sh[PW-1:SW-1];
    if (neg_q) begin
      res_o = over ? S_MIN : ('0 - mag_sh[SW-1:0]);
    end else begin
      res_o = over ? S_MAX : mag_sh[SW-1:0];
    end
  end

  assign done_o = done_q;
  assign raw_o  = prod_q[OPB_W-1:0];

endmodule

// ===== hw/rtl/linear_adrc_eso_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear ADRC controller with third-order extended state observer
// Requests are handled one at a time: in_ready is high only while idle.
// Each request runs 12 passes through the shared digit-serial multiplier
// and 12 saturating add steps, all in order under the microcode sequencer.
// Reset: estimates and last drive clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
module linear_adrc_eso_controller
  import adrc_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned STATE_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] measured_angle_i,
  input  logic [15:0]        step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_o,
  output logic               in_deadband_o,
  output logic               saturated_o,
  output logic signed [15:0] position_estimate_o
);

  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned EW = (SW + 1 > FRAC_BITS + 17) ? SW + 1 : FRAC_BITS + 17;
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam int unsigned N_INSTR = 24;
  localparam int unsigned PC_W    = $clog2(N_INSTR);
  localparam logic [PC_W-1:0] LAST_PC = PC_W'(N_INSTR - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic {
    OP_ADD,
    OP_MUL
  } op_e;

  typedef enum logic [3:0] {
    A_W, A_W2, A_E, A_DRV, A_D1, A_D2, A_D3, A_RATE, A_DIST
  } asel_e;

  typedef enum logic [3:0] {
    B_W, B_BETA1, B_BETA2, B_BETA3, B_PUSH, B_DT, B_KP, B_KD, B_INV
  } bsel_e;

  typedef enum logic [2:0] {
    X_ZERO, X_POS, X_RATE, X_DIST, X_D1, X_D2, X_TGT, X_M
  } xsel_e;

  typedef enum logic [1:0] {
    Y_ZERO, Y_MEAS, Y_M, Y_POS
  } ysel_e;

  typedef enum logic [3:0] {
    DST_W2, DST_B3, DST_M, DST_E, DST_D1, DST_D2, DST_D3, DST_POS, DST_RATE, DST_DIST
  } dst_e;

  typedef struct packed {
    op_e        op;
    asel_e      asel;
    bsel_e      bsel;
    logic [1:0] digits;
    shift_e     shift;
    logic       a_signed;
    xsel_e      xsel;
    ysel_e      ysel;
    logic       y_neg;
    dst_e       dst;
  } instr_t;

  typedef struct packed {
    logic        sat;
    logic [15:0] value;
  } sat16_t;

  function automatic instr_t mk_mul(input asel_e a, input bsel_e b, input logic [1:0] n,
                                    input shift_e s, input logic sg, input dst_e d);
    instr_t i;
    i          = '0;
    i.op       = OP_MUL;
    i.asel     = a;
    i.bsel     = b;
    i.digits   = n;
    i.shift    = s;
    i.a_signed = sg;
    i.dst      = d;
    return i;
  endfunction

  function automatic instr_t mk_add(input xsel_e x, input ysel_e y, input logic ng,
                                    input dst_e d);
    instr_t i;
    i       = '0;
    i.op    = OP_ADD;
    i.xsel  = x;
    i.ysel  = y;
    i.y_neg = ng;
    i.dst   = d;
    return i;
  endfunction

  function automatic instr_t ucode(input logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      5'd0:    i = mk_mul(A_W, B_W, 2'd1, SH_0, 1'b0, DST_W2);
      5'd1:    i = mk_mul(A_W2, B_W, 2'd1, SH_0, 1'b0, DST_B3);
      5'd2:    i = mk_add(X_POS, Y_MEAS, 1'b1, DST_E);
      5'd3:    i = mk_mul(A_E, B_BETA1, 2'd2, SH_8, 1'b1, DST_M);
      5'd4:    i = mk_add(X_RATE, Y_M, 1'b1, DST_D1);
      5'd5:    i = mk_mul(A_E, B_BETA2, 2'd3, SH_16, 1'b1, DST_M);
      5'd6:    i = mk_add(X_DIST, Y_M, 1'b1, DST_D2);
      5'd7:    i = mk_mul(A_DRV, B_PUSH, 2'd2, SH_0, 1'b1, DST_M);
      5'd8:    i = mk_add(X_D2, Y_M, 1'b0, DST_D2);
      5'd9:    i = mk_mul(A_E, B_BETA3, 2'd3, SH_24, 1'b1, DST_M);
      5'd10:   i = mk_add(X_ZERO, Y_M, 1'b1, DST_D3);
      5'd11:   i = mk_mul(A_D1, B_DT, 2'd1, SH_16, 1'b1, DST_M);
      5'd12:   i = mk_add(X_POS, Y_M, 1'b0, DST_POS);
      5'd13:   i = mk_mul(A_D2, B_DT, 2'd1, SH_16, 1'b1, DST_M);
      5'd14:   i = mk_add(X_RATE, Y_M, 1'b0, DST_RATE);
      5'd15:   i = mk_mul(A_D3, B_DT, 2'd1, SH_16, 1'b1, DST_M);
      5'd16:   i = mk_add(X_DIST, Y_M, 1'b0, DST_DIST);
      5'd17:   i = mk_add(X_TGT, Y_POS, 1'b1, DST_E);
      5'd18:   i = mk_mul(A_E, B_KP, 2'd1, SH_8, 1'b1, DST_M);
      5'd19:   i = mk_add(X_M, Y_ZERO, 1'b0, DST_D1);
      5'd20:   i = mk_mul(A_RATE, B_KD, 2'd1, SH_8, 1'b1, DST_M);
      5'd21:   i = mk_add(X_D1, Y_M, 1'b1, DST_D1);
      5'd22:   i = mk_mul(A_DIST, B_INV, 2'd1, SH_16, 1'b1, DST_M);
      5'd23:   i = mk_add(X_D1, Y_M, 1'b1, DST_D1);
      default: i = mk_add(X_ZERO, Y_ZERO, 1'b0, DST_E);
    endcase
    return i;
  endfunction

  function automatic logic [EW-1:0] sext(input logic [SW-1:0] v);
    return {{(EW-SW){v[SW-1]}}, v};
  endfunction

  function automatic logic [SW-1:0] sat_sw(input logic [EW-1:0] v);
    logic fits;
    fits = (&v[EW-1:SW-1]) | ~(|v[EW-1:SW-1]);
    if (fits) begin
      return v[SW-1:0];
    end
    return v[EW-1] ? S_MIN : S_MAX;
  endfunction

  function automatic logic [SW-1:0] to_fixed(input logic [15:0] v);
    logic [EW-1:0] w;
    w = {{(EW-16){v[15]}}, v} << FRAC_BITS;
    return sat_sw(w);
  endfunction

  function automatic sat16_t to_int16(input logic [SW-1:0] x);
    sat16_t r;
    logic [SW-1:0] mag;
    logic [SW-1:0] ux;
    mag = x[SW-1] ? ('0 - x) : x;
    ux  = mag >> FRAC_BITS;
    if (x[SW-1]) begin
      r.sat   = (ux > SW'(32768));
      r.value = r.sat ? 16'h8000 : (16'h0000 - ux[15:0]);
    end else begin
      r.sat   = (ux > SW'(32767));
      r.value = r.sat ? 16'h7fff : ux[15:0];
    end
    return r;
  endfunction

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            out_valid_q;
  logic [15:0]     drive_q;
  logic            inband_q;
  logic            sat_q;
  logic [15:0]     pos_out_q;

  logic [15:0] tgt_q;
  logic [15:0] w_q;
  logic [15:0] b0_q;
  logic [15:0] inv_q;
  logic [15:0] kp_q;
  logic [15:0] kd_q;
  logic [14:0] db_q;

  logic [SW-1:0] pos_q;
  logic [SW-1:0] rate_q;
  logic [SW-1:0] dist_q;
  logic [15:0]   last_drive_q;

  logic [15:0]      meas_q;
  logic [15:0]      dt_q;
  logic [SW-1:0]    e_q;
  logic [SW-1:0]    d1_q;
  logic [SW-1:0]    d2_q;
  logic [SW-1:0]    d3_q;
  logic [SW-1:0]    m_q;
  logic [31:0]      w2_q;
  logic [OPB_W-1:0] b3_q;

  instr_t           ins;
  mul_cmd_t         mul_cmd;
  logic [SW-1:0]    mul_a;
  logic [OPB_W-1:0] mul_b;
  logic             mul_done;
  logic [OPB_W-1:0] mul_raw;
  logic [SW-1:0]    mul_res;
  logic [SW-1:0]    add_x;
  logic [SW-1:0]    add_y;
  logic [EW-1:0]    add_ye;
  logic [SW-1:0]    add_res;
  logic [SW-1:0]    wr_val;
  logic             wr_en;
  logic             in_acc;
  logic             fin_load;
  logic             pc_last;
  logic [16:0]      err;
  logic [16:0]      err_abs;
  logic             inband;
  sat16_t           drv;
  sat16_t           pos_int;
  logic [15:0]      drive_d;

  assign ins      = ucode(pc_q);
  assign pc_last  = (pc_q == LAST_PC);
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Shared multiplier operands
  always_comb begin
    mul_cmd.start    = (state_q == ST_EXEC) && (ins.op == OP_MUL);
    mul_cmd.a_signed = ins.a_signed;
    mul_cmd.digits   = ins.digits;
    mul_cmd.shift    = ins.shift;
    unique case (ins.asel)
      A_W:     mul_a = SW'(w_q);
      A_W2:    mul_a = SW'(w2_q);
      A_E:     mul_a = e_q;
      A_DRV:   mul_a = {{(SW-16){last_drive_q[15]}}, last_drive_q};
      A_D1:    mul_a = d1_q;
      A_D2:    mul_a = d2_q;
      A_D3:    mul_a = d3_q;
      A_RATE:  mul_a = rate_q;
      A_DIST:  mul_a = dist_q;
      default: mul_a = '0;
    endcase
    unique case (ins.bsel)
      B_W:     mul_b = OPB_W'(w_q);
      B_BETA1: mul_b = OPB_W'(w_q) + (OPB_W'(w_q) << 1);
      B_BETA2: mul_b = OPB_W'(w2_q) + (OPB_W'(w2_q) << 1);
      B_BETA3: mul_b = b3_q;
      B_PUSH:  mul_b = OPB_W'(b0_q) << (FRAC_BITS - 8);
      B_DT:    mul_b = OPB_W'(dt_q);
      B_KP:    mul_b = OPB_W'(kp_q);
      B_KD:    mul_b = OPB_W'(kd_q);
      B_INV:   mul_b = OPB_W'(inv_q);
      default: mul_b = '0;
    endcase
  end

  adrc_mul #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (mul_cmd),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .done_o(mul_done),
    .raw_o (mul_raw),
    .res_o (mul_res)
  );

  // Saturating add step
  always_comb begin
    unique case (ins.xsel)
      X_ZERO:  add_x = '0;
      X_POS:   add_x = pos_q;
      X_RATE:  add_x = rate_q;
      X_DIST:  add_x = dist_q;
      X_D1:    add_x = d1_q;
      X_D2:    add_x = d2_q;
      X_TGT:   add_x = to_fixed(tgt_q);
      default: add_x = m_q;
    endcase
    unique case (ins.ysel)
      Y_ZERO:  add_y = '0;
      Y_MEAS:  add_y = to_fixed(meas_q);
      Y_M:     add_y = m_q;
      default: add_y = pos_q;
    endcase
    if (!ins.y_neg) begin
      add_ye = sext(add_y);
    end else if (add_y == S_MIN) begin
      add_ye = sext(S_MAX);
    end else begin
      add_ye = '0 - sext(add_y);
    end
    add_res = sat_sw(sext(add_x) + add_ye);
  end

  assign wr_en  = ((state_q == ST_EXEC) && (ins.op == OP_ADD)) ||
                  ((state_q == ST_WAIT) && mul_done);
  assign wr_val = (state_q == ST_WAIT) ? mul_res : add_res;

  // Final drive and deadband
  always_comb begin
    err     = {tgt_q[15], tgt_q} - {meas_q[15], meas_q};
    err_abs = err[16] ? (17'h0 - err) : err;
    inband  = err_abs < {2'b00, db_q};
    drv     = to_int16(d1_q);
    pos_int = to_int16(pos_q);
    drive_d = inband ? 16'h0000 : drv.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      inband_q    <= 1'b0;
      sat_q       <= 1'b0;
      pos_out_q   <= '0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
            pc_q    <= '0;
          end
        end
        ST_EXEC: begin
          if (ins.op == OP_MUL) begin
            state_q <= ST_WAIT;
          end else if (pc_last) begin
            state_q <= ST_FIN;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (mul_done) begin
            if (pc_last) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_EXEC;
              pc_q    <= pc_q + 1'b1;
            end
          end
        end
        default: begin
          if (fin_load) begin
            drive_q     <= drive_d;
            inband_q    <= inband;
            sat_q       <= drv.sat & ~inband;
            pos_out_q   <= pos_int.value;
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= 16'd0;
      w_q   <= 16'd5120;
      b0_q  <= 16'd3200;
      inv_q <= 16'd5243;
      kp_q  <= 16'd64000;
      kd_q  <= 16'd1280;
      db_q  <= 15'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET:         tgt_q <= cfg_data_i;
        REG_BANDWIDTH:      w_q   <= cfg_data_i;
        REG_PLANT_GAIN:     b0_q  <= cfg_data_i;
        REG_PLANT_GAIN_INV: inv_q <= cfg_data_i;
        REG_PROP_GAIN:      kp_q  <= cfg_data_i;
        REG_RATE_GAIN:      kd_q  <= cfg_data_i;
        REG_DEADBAND:       db_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      rate_q       <= '0;
      dist_q       <= '0;
      last_drive_q <= '0;
    end else begin
      if (wr_en) begin
        unique case (ins.dst)
          DST_POS:  pos_q  <= wr_val;
          DST_RATE: rate_q <= wr_val;
          DST_DIST: dist_q <= wr_val;
          default: ;
        endcase
      end
      if (fin_load) begin
        last_drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= measured_angle_i;
      dt_q   <= step_time_i;
    end
    if (wr_en) begin
      unique case (ins.dst)
        DST_W2:  w2_q <= mul_raw[31:0];
        DST_B3:  b3_q <= mul_raw;
        DST_M:   m_q  <= wr_val;
        DST_E:   e_q  <= wr_val;
        DST_D1:  d1_q <= wr_val;
        DST_D2:  d2_q <= wr_val;
        DST_D3:  d3_q <= wr_val;
        default: ;
      endcase
    end
  end

  assign in_ready_o          = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign drive_o             = drive_q;
  assign in_deadband_o       = inband_q;
  assign saturated_o         = sat_q;
  assign position_estimate_o = pos_out_q;

endmodule

// ===== dv/linear_adrc_eso_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear ADRC controller testbench
// Drives angle samples through the request channel and collects drive results
// under random idling and two long output hold-offs. A fixed-point copy of the
// observer and control law predicts each result; every field is compared in
// order. Register settings change only between phases, once the block is idle.
// ----------------------------------------------------------------------------
module linear_adrc_eso_controller_tb;
  import adrc_pkg::*;

  localparam int unsigned EST_FRAC     = 16;
  localparam int          PHASE_ITEMS  = 190;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_OFF     = 600;
  localparam int          TIMEOUT_NS   = 6_000_000;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [47:0] est_t;

  localparam wide_t EST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam wide_t EST_MIN = 64'shFFFF_8000_0000_0000;

  typedef enum int {
    SET_DEFAULT,
    SET_LIVE,
    SET_RANDOM,
    SET_ZERO,
    SET_MAX
  } setting_kind_e;

  typedef struct {
    logic signed [15:0] drive;
    bit                 in_deadband;
    bit                 saturated;
    logic signed [15:0] position;
  } drive_result_t;

  class adrc_scoreboard;
    logic signed [15:0] target;
    logic [15:0]        bandwidth, plant_gain, plant_gain_inv, prop_gain, rate_gain;
    logic [14:0]        deadband;
    est_t               pos_est, rate_est, dist_est;
    logic signed [15:0] last_drive;
    drive_result_t      expected_q[$];
    int                 mismatches;

    function new();
      target         = '0;
      bandwidth      = 16'd5120;
      plant_gain     = 16'd3200;
      plant_gain_inv = 16'd5243;
      prop_gain      = 16'd64000;
      rate_gain      = 16'd1280;
      deadband       = 15'd3;
      pos_est        = '0;
      rate_est       = '0;
      dist_est       = '0;
      last_drive     = '0;
      mismatches     = 0;
    endfunction

    function void set_register(reg_index_e idx, logic [15:0] value);
      case (idx)
        REG_TARGET:         target = value;
        REG_BANDWIDTH:      bandwidth = value;
        REG_PLANT_GAIN:     plant_gain = value;
        REG_PLANT_GAIN_INV: plant_gain_inv = value;
        REG_PROP_GAIN:      prop_gain = value;
        REG_RATE_GAIN:      rate_gain = value;
        REG_DEADBAND:       deadband = value[14:0];
        default: ;
      endcase
    endfunction

    function wide_t clamp_est(wide_t x);
      if (x > EST_MAX) return EST_MAX;
      if (x < EST_MIN) return EST_MIN;
      return x;
    endfunction

    function wide_t sat_add(wide_t a, wide_t b);
      return clamp_est(a + b);
    endfunction

    function wide_t sat_neg(wide_t a);
      return clamp_est(-a);
    endfunction

    function wide_t sat_sub(wide_t a, wide_t b);
      return sat_add(a, sat_neg(b));
    endfunction

    // exact product, truncate toward zero, saturate to the estimate range
    function wide_t scaled_product(wide_t a, logic [63:0] b, int unsigned sh);
      logic [63:0]  mag_a;
      logic [127:0] prod;
      mag_a = a[63] ? 64'(-a) : 64'(a);
      prod  = ({64'd0, mag_a} * {64'd0, b}) >> sh;
      if (!a[63]) return (prod > 128'h7FFF_FFFF_FFFF) ? EST_MAX : wide_t'(prod[63:0]);
      return (prod > 128'h8000_0000_0000) ? EST_MIN : -wide_t'(prod[63:0]);
    endfunction

    function logic signed [15:0] to_sat16(wide_t x, output bit sat);
      logic [63:0] mag;
      mag = (x[63] ? 64'(-x) : 64'(x)) >> EST_FRAC;
      sat = 1'b0;
      if (x[63]) begin
        if (mag > 64'd32768) begin
          sat = 1'b1;
          return 16'sh8000;
        end
        return 16'(-mag);
      end
      if (mag > 64'd32767) begin
        sat = 1'b1;
        return 16'sh7FFF;
      end
      return mag[15:0];
    endfunction

    function void note_sample(logic signed [15:0] meas, logic [15:0] dt);
      logic [63:0]   w, beta1, beta2, beta3;
      wide_t         meas_fx, tgt_fx, eps, push, d1, d2, d3, u;
      int            err;
      bit            pos_sat;
      drive_result_t r;
      w       = 64'(bandwidth);
      beta1   = 64'd3 * w;
      beta2   = 64'd3 * w * w;
      beta3   = w * w * w;
      meas_fx = wide_t'(meas) <<< EST_FRAC;
      tgt_fx  = wide_t'(target) <<< EST_FRAC;

      eps  = sat_sub(wide_t'(pos_est), meas_fx);
      push = scaled_product(wide_t'(last_drive) * wide_t'(plant_gain),
                            64'd1 << (EST_FRAC - 8), 0);
      d1 = sat_sub(wide_t'(rate_est), scaled_product(eps, beta1, 8));
      d2 = sat_add(sat_sub(wide_t'(dist_est), scaled_product(eps, beta2, 16)), push);
      d3 = sat_neg(scaled_product(eps, beta3, 24));
      pos_est  = est_t'(sat_add(wide_t'(pos_est), scaled_product(d1, 64'(dt), 16)));
      rate_est = est_t'(sat_add(wide_t'(rate_est), scaled_product(d2, 64'(dt), 16)));
      dist_est = est_t'(sat_add(wide_t'(dist_est), scaled_product(d3, 64'(dt), 16)));

      u = scaled_product(sat_sub(tgt_fx, wide_t'(pos_est)), 64'(prop_gain), 8);
      u = sat_sub(u, scaled_product(wide_t'(rate_est), 64'(rate_gain), 8));
      u = sat_sub(u, scaled_product(wide_t'(dist_est), 64'(plant_gain_inv), 16));
      r.drive = to_sat16(u, r.saturated);

      err = int'(target) - int'(meas);
      if (err < 0) err = -err;
      r.in_deadband = (err < int'(deadband));
      if (r.in_deadband) begin
        r.drive     = '0;
        r.saturated = 1'b0;
      end
      last_drive = r.drive;
      r.position = to_sat16(wide_t'(pos_est), pos_sat);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_result(logic signed [15:0] drive, logic in_band, logic sat,
                      logic signed [15:0] position);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, drive %0d", drive));
        return;
      end
      want = expected_q.pop_front();
      if (drive !== want.drive)
        report_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
      if (in_band !== want.in_deadband)
        report_mismatch($sformatf("in_deadband %b, expected %b", in_band, want.in_deadband));
      if (sat !== want.saturated)
        report_mismatch($sformatf("saturated %b, expected %b", sat, want.saturated));
      if (position !== want.position)
        report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] measured_angle;
  logic [15:0]        step_time;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] drive;
  logic               in_deadband;
  logic               saturated;
  logic signed [15:0] position_estimate;

  adrc_scoreboard sb;
  logic [15:0]    setting [7];
  bit             sender_idles;
  bit             receiver_idles;

  linear_adrc_eso_controller u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .measured_angle_i    (measured_angle),
    .step_time_i         (step_time),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .drive_o             (drive),
    .in_deadband_o       (in_deadband),
    .saturated_o         (saturated),
    .position_estimate_o (position_estimate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_sample(input logic signed [15:0] angle, input logic [15:0] dt);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    measured_angle <= angle;
    step_time      <= dt;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(angle, dt);
  endtask

  // drop valid, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_setting();
    for (int i = 0; i < int'(REG_UNUSED); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index_e'(i);
      cfg_data  <= setting[i];
      @(posedge clk);
      sb.set_register(reg_index_e'(i), setting[i]);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic choose_setting(input setting_kind_e kind);
    int b0;
    int inv;
    case (kind)
      SET_DEFAULT: begin
        setting[REG_TARGET]         = 16'($urandom_range(0, 4000) - 2000);
        setting[REG_BANDWIDTH]      = 16'd5120;
        setting[REG_PLANT_GAIN]     = 16'd3200;
        setting[REG_PLANT_GAIN_INV] = 16'd5243;
        setting[REG_PROP_GAIN]      = 16'd64000;
        setting[REG_RATE_GAIN]      = 16'd1280;
        setting[REG_DEADBAND]       = 16'd3;
      end
      SET_LIVE: begin
        b0  = $urandom_range(256, 8000);
        inv = 16777216 / b0;
        if (inv > 65535) inv = 65535;
        setting[REG_TARGET]         = 16'($urandom_range(0, 8000) - 4000);
        setting[REG_BANDWIDTH]      = 16'($urandom_range(256, 8192));
        setting[REG_PLANT_GAIN]     = 16'(b0);
        setting[REG_PLANT_GAIN_INV] = 16'(inv);
        setting[REG_PROP_GAIN]      = 16'($urandom);
        setting[REG_RATE_GAIN]      = 16'($urandom_range(0, 4096));
        setting[REG_DEADBAND]       = 16'($urandom_range(0, 16));
      end
      SET_RANDOM: begin
        foreach (setting[i]) setting[i] = 16'($urandom);
      end
      SET_ZERO: begin
        foreach (setting[i]) setting[i] = '0;
      end
      default: begin
        foreach (setting[i]) setting[i] = 16'hFFFF;
        setting[REG_TARGET] = 16'h7FFF;
      end
    endcase
  endtask

  // mostly samples near the setpoint with a plausible step time, the rest noise
  task automatic random_phase(input int count);
    int target;
    int spread;
    int angle;
    int dt;
    target = int'($signed(setting[REG_TARGET]));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0:       spread = int'(setting[REG_DEADBAND][14:0]) + 2;
          1:       spread = 64;
          default: spread = 2048;
        endcase
        angle = target + $urandom_range(0, 2 * spread) - spread;
        if (angle > 32767) angle = 32767;
        if (angle < -32768) angle = -32768;
        dt = $urandom_range(16, 1024);
      end else begin
        angle = $urandom;
        dt    = $urandom;
      end
      send_sample(16'(angle), 16'(dt));
    end
  endtask

  initial begin
    int stall;
    int results_seen;
    out_ready <= 1'b0;
    results_seen = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (results_seen == 400 || results_seen == 1100) stall = HOLD_OFF;
      else stall = receiver_idles ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(drive, in_deadband, saturated, position_estimate);
      results_seen++;
    end
  end

  initial begin
    setting_kind_e plan [8];
    plan = '{SET_DEFAULT, SET_LIVE, SET_RANDOM, SET_LIVE,
             SET_ZERO, SET_LIVE, SET_MAX, SET_LIVE};
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_TARGET;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    measured_angle <= '0;
    step_time      <= '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: deadband edges, extreme angles, zero and full step time
    send_sample(16'sd0, 16'd328);
    send_sample(16'sd2, 16'd328);
    send_sample(-16'sd2, 16'd328);
    send_sample(16'sd3, 16'd328);
    send_sample(-16'sd3, 16'd328);
    send_sample(16'sh7FFF, 16'hFFFF);
    send_sample(16'sh8000, 16'hFFFF);
    send_sample(16'sh8000, 16'h0000);
    send_sample(16'sd100, 16'h0000);
    send_sample(16'sh5555, 16'hAAAA);
    send_sample(16'shAAAA, 16'h5555);
    send_sample(16'sd0, 16'h8000);
    settle();

    // lowest setpoint, widest deadband, every gain zero
    foreach (setting[i]) setting[i] = '0;
    setting[REG_TARGET]   = 16'h8000;
    setting[REG_DEADBAND] = 16'h7FFF;
    program_setting();
    send_sample(16'sh8000, 16'hFFFF);
    send_sample(-16'sd2, 16'd1000);
    send_sample(-16'sd1, 16'd1000);
    send_sample(16'sh7FFF, 16'hFFFF);
    settle();

    // highest setpoint, every gain at full scale
    choose_setting(SET_MAX);
    program_setting();
    send_sample(16'sh7FFF, 16'hFFFF);
    send_sample(16'sh8000, 16'hFFFF);
    send_sample(16'sd0, 16'hFFFF);
    settle();

    for (int p = 0; p < 8; p++) begin
      sender_idles   = (p % 3) != 1;
      receiver_idles = (p % 4) != 2;
      choose_setting(plan[p]);
      program_setting();
      random_phase(PHASE_ITEMS);
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
